// File: hdl/ust_pkg.sv
`default_nettype none

package ust_pkg;

    localparam int VALUE_W       = 32;
    localparam int CAP_W         = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } ust_op_t;

    typedef struct packed {
        ust_op_t                   opcode;
        logic signed [VALUE_W-1:0] element_value;
    } ust_in_t;

    typedef struct packed {
        logic             success;
        logic [CAP_W-1:0] element_count;
    } ust_out_t;

    typedef struct packed {
        logic     valid;
        ust_out_t data;
    } ust_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOVE
    } ust_state_t;

endpackage

`default_nettype wire

// File: hdl/unique_set_table.sv
// Set of up to DEPTH distinct 32-bit values, kept compactly in one memory.
// Input items arrive on the s_ channel (valid/ready) and carry an opcode
// (insert or remove) and a value. Every item gives exactly one result item
// on the m_ channel: a success flag and the element count after the item.
// The capacity register is written through cfg_wr_en and cfg_wr_data; the
// user is to write it only while the block is idle, and the block itself
// does not enforce this. The capacity register resets to 64.
// An item is scanned against the stored slots one memory read per cycle,
// stopping early at a match. A remove that finds its value passes through
// the extra state ST_MOVE to move the last slot into the freed one.
// The block works on one item at a time and takes the next item in the
// cycle after a result is loaded; it cannot accept a new item before it
// is through with the last one.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and scans the next item, and holds before its write
// back until the register is free. Reset empties the set at once.
`default_nettype none

module unique_set_table
    import ust_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ust_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ust_out_t              m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ust_res_t           res;
    logic               out_free;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;
    logic               m_valid_reg;
    ust_out_t           m_data_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    ust_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_free    (out_free),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    ust_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_data_reg <= res.data;
        end
    end

    a_res_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> out_free)
        else $error("Result produced while the output register is occupied.");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A second item was offered acceptance while one is in work.");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> !res.valid)
        else $error("Two results were produced in consecutive cycles.");

    a_busy_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> s_ready)
        else $error("The block did not return to idle after its result.");

endmodule

`default_nettype wire

// File: hdl/ust_ram.sv
`default_nettype none

module ust_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/ust_ctrl.sv
`default_nettype none

module ust_ctrl
    import ust_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ust_in_t            s_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [CAP_W-1:0]   cfg_wr_data,
    input  wire logic               out_free,
    output ust_res_t                res,
    output logic                    ram_wr_en,
    output logic      [ADDR_W-1:0]  ram_wr_addr,
    output logic      [VALUE_W-1:0] ram_wr_data,
    output logic                    ram_rd_en,
    output logic      [ADDR_W-1:0]  ram_rd_addr,
    input  wire logic [VALUE_W-1:0] ram_rd_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    ust_state_t         state_reg,     state_next;
    ust_op_t            op_reg,        op_next;
    logic [VALUE_W-1:0] val_reg,       val_next;
    logic [CNT_W-1:0]   cnt_reg,       cnt_next;
    logic [CNT_W-1:0]   scan_idx_reg,  scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]  cmp_idx_reg,   cmp_idx_next;
    logic               found_reg,     found_next;
    logic [ADDR_W-1:0]  pos_reg,       pos_next;
    logic [CAP_W-1:0]   cap_reg;

    logic [CNT_W-1:0]   last_idx;
    logic               ins_ok;

    assign last_idx = cnt_reg - CNT_W'(1);
    assign ins_ok   = (CMP_W'(cnt_reg) < CMP_W'(cap_reg))
                      && (cnt_reg < CNT_W'(DEPTH)) && !found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;

        s_ready                = 1'b0;
        res.valid              = 1'b0;
        res.data.success       = 1'b0;
        res.data.element_count = CAP_W'(cnt_reg);
        ram_wr_en              = 1'b0;
        ram_wr_addr            = cnt_reg[ADDR_W-1:0];
        ram_wr_data            = val_reg;
        ram_rd_en              = 1'b0;
        ram_rd_addr            = scan_idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next        = s_data.opcode;
                    val_next       = s_data.element_value;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Reads are issued one slot a cycle; each compare sees the
                // slot read in the cycle before.
                if (cmp_valid_reg && (ram_rd_data == val_reg)) begin
                    found_next     = 1'b1;
                    pos_next       = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_DECIDE;
                end else if (scan_idx_reg < cnt_reg) begin
                    ram_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end else begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (op_reg == OP_INSERT) begin
                    if (out_free) begin
                        ram_wr_en              = ins_ok;
                        cnt_next               = cnt_reg + CNT_W'(ins_ok);
                        res.valid              = 1'b1;
                        res.data.success       = ins_ok;
                        res.data.element_count = CAP_W'(cnt_next);
                        state_next             = ST_IDLE;
                    end
                end else if (found_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = last_idx[ADDR_W-1:0];
                    state_next  = ST_MOVE;
                end else if (out_free) begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE: begin
                // The last stored value fills the slot of the removed one.
                if (out_free) begin
                    ram_wr_en              = 1'b1;
                    ram_wr_addr            = pos_reg;
                    ram_wr_data            = ram_rd_data;
                    cnt_next               = last_idx;
                    res.valid              = 1'b1;
                    res.data.success       = 1'b1;
                    res.data.element_count = CAP_W'(last_idx);
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
